// ----- design/odh_pkg.sv -----
// Shared definitions for the ordered dither halftoner: register indexes,
// matrix mode codes, threshold tables and the threshold function.
// Stands alone; the top level refers to it by scoped names.
package odh_pkg;

   localparam int unsigned DEFAULT_MAX_WIDTH = 16384;

   // Configuration register indexes (byte address is four times the index).
   localparam logic REG_MATRIX_MODE = 1'b0;
   localparam logic REG_IMAGE_WIDTH = 1'b1;

   localparam logic [14:0] IMAGE_WIDTH_RESET = 15'd1;

   // Matrix mode codes.
   localparam logic [3:0] MODE_FIXED128 = 4'd0;
   localparam logic [3:0] MODE_BAYER2   = 4'd1;
   localparam logic [3:0] MODE_BAYER4   = 4'd2;
   localparam logic [3:0] MODE_BAYER8   = 4'd3;
   localparam logic [3:0] MODE_BAYER16  = 4'd4;
   localparam logic [3:0] MODE_BAYER8X4 = 4'd5;
   localparam logic [3:0] MODE_CLUS4    = 4'd6;
   localparam logic [3:0] MODE_CLUS8    = 4'd7;
   localparam logic [3:0] MODE_LINE4    = 4'd8;

   // Clustered-dot tables, indexed by {row, column}.
   localparam logic [3:0] CLUS4_TAB [0:15] = '{
      4'd12, 4'd5,  4'd6,  4'd13,
      4'd4,  4'd0,  4'd1,  4'd7,
      4'd11, 4'd3,  4'd2,  4'd8,
      4'd15, 4'd10, 4'd9,  4'd14
   };

   localparam logic [5:0] CLUS8_TAB [0:63] = '{
      6'd24, 6'd10, 6'd12, 6'd26, 6'd35, 6'd47, 6'd49, 6'd37,
      6'd8,  6'd0,  6'd2,  6'd14, 6'd45, 6'd59, 6'd61, 6'd51,
      6'd22, 6'd6,  6'd4,  6'd16, 6'd43, 6'd57, 6'd63, 6'd53,
      6'd30, 6'd20, 6'd18, 6'd28, 6'd33, 6'd41, 6'd55, 6'd39,
      6'd34, 6'd46, 6'd48, 6'd36, 6'd25, 6'd11, 6'd13, 6'd27,
      6'd44, 6'd58, 6'd60, 6'd50, 6'd9,  6'd1,  6'd3,  6'd15,
      6'd42, 6'd56, 6'd62, 6'd52, 6'd23, 6'd7,  6'd5,  6'd17,
      6'd32, 6'd40, 6'd54, 6'd38, 6'd31, 6'd21, 6'd19, 6'd29
   };

   // Recursive Bayer index for a matrix of 2^levels on a side.
   function automatic logic [7:0] bayer_index(input logic [2:0] levels,
                                              input logic [3:0] x,
                                              input logic [3:0] y);
      logic [7:0] v;
      v = 8'd0;
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < levels) begin
            v = {v[5:0], x[k] ^ y[k], y[k]};
         end
      end
      return v;
   endfunction

   // Threshold in 0..255 for the given mode at column x, row y (both mod 16).
   // The scaling divisions are all by powers of two, so most cases place
   // the index in the upper bits with a fixed offset; BAYER8 is 254 minus it.
   function automatic logic [7:0] threshold(input logic [3:0] mode,
                                            input logic [3:0] x,
                                            input logic [3:0] y);
      logic [7:0] b;
      logic [7:0] t;
      b = 8'd0;
      case (mode)
         MODE_BAYER2: begin
            b = bayer_index(3'd1, x, y);
            t = {b[1:0], 6'd32};
         end
         MODE_BAYER4: begin
            b = bayer_index(3'd2, x, y);
            t = {b[3:0], 4'd8};
         end
         MODE_BAYER8: begin
            b = bayer_index(3'd3, x, y);
            t = 8'd254 - {b[5:0], 2'b00};
         end
         MODE_BAYER16: begin
            b = bayer_index(3'd4, x, y);
            t = b;
         end
         MODE_BAYER8X4: begin
            b = bayer_index(3'd3, x, {2'b00, y[1:0]});
            t = {b[5:0], 2'd2};
         end
         MODE_CLUS4: t = {CLUS4_TAB[{y[1:0], x[1:0]}], 4'd8};
         MODE_CLUS8: t = {CLUS8_TAB[{y[2:0], x[2:0]}], 2'd2};
         MODE_LINE4: t = {y[1:0], 6'd32};
         default:    t = 8'd128;
      endcase
      return t;
   endfunction

endpackage

// ----- design/odh_req_if.sv -----
// Pixel request channel of the ordered dither halftoner: valid, ready and
// one gray pixel with its start-of-image flag. No dependencies.
interface odh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] gray_pixel;
   logic       start_of_image;

   modport source (output valid, output gray_pixel, output start_of_image, input ready);
   modport sink   (input valid, input gray_pixel, input start_of_image, output ready);
endinterface

// ----- design/odh_rsp_if.sv -----
// Packed byte channel of the ordered dither halftoner: valid, ready, one
// byte of halftone bits and its row-end flag. No dependencies.
interface odh_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packed_byte;
   logic       row_end;

   modport source (output valid, output packed_byte, output row_end, input ready);
   modport sink   (input valid, input packed_byte, input row_end, output ready);
endinterface

// ----- design/ordered_dither_halftoner.sv -----
// Ordered dither halftoner top level: pixel input register, threshold
// compare and bit packing, packed byte output register, APB-style CSRs.
// Depends on odh_pkg, odh_req_if and odh_rsp_if.
//
//   channel  direction  handshake          payload
//   req      in         valid/ready        gray_pixel[7:0], start_of_image
//   rsp      out        valid/ready        packed_byte[7:0], row_end
//   csr      in         psel/penable, APB  matrix_mode @0x0, image_width @0x4
//
// One pixel request is taken every clock cycle unless a stalled output holds
// the input register. A pixel waits in the input register, and the byte it
// completes is loaded into the output register, which raises rsp.valid; the
// byte leaves when rsp.ready is high.
// The rate is set by the single compare-and-pack pass, which is one short
// table lookup and an 8-bit compare.
// Reset (synchronous, active high) clears the counters, the pending bits,
// both valid flags and the registers to their reset values.
// A stalled output holds its byte; the input register keeps its pixel until
// the output register can take the result, and req.ready drops only then.
module ordered_dither_halftoner #(
   parameter int unsigned MAX_WIDTH = odh_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   odh_req_if.sink     req,
   odh_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Column counter width, and a compare width that holds both the
   // 15-bit width register and MAX_WIDTH itself.
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = (CW + 1 > 15) ? CW + 1 : 15;
   localparam int XW = (CW > 4) ? CW : 4;

   // Configuration registers.
   logic [3:0]  mode_ff, mode_in;
   logic [14:0] width_ff, width_in;

   // Input register stage.
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_gray_ff, in_gray_in;
   logic        in_start_ff, in_start_in;

   // Raster state.
   logic [CW-1:0] col_ff, col_in;
   logic [3:0]    row_ff, row_in;
   logic [7:0]    acc_ff, acc_in;

   // Output register stage.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_end_ff, rsp_end_in;

   logic          out_free;
   logic          advance;
   logic          csr_write;
   logic [CW-1:0] col_s;
   logic [3:0]    row_s;
   logic [7:0]    acc_s;
   logic [XW-1:0] col_x;
   logic [EW-1:0] width_ext;
   logic [EW-1:0] eff_width;
   logic [EW-1:0] eff_last;
   logic          last;
   logic          emit;
   logic          dark;
   logic [7:0]    acc_set;
   logic [7:0]    thr;

   // The output register is free when empty or being drained this cycle.
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.packed_byte = rsp_byte_ff;
   assign rsp.row_end     = rsp_end_ff;

   // APB port: zero-wait writes, register chosen by address bit 2.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      mode_in  = mode_ff;
      width_in = width_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            odh_pkg::REG_MATRIX_MODE: mode_in  = csr_pwdata[3:0];
            odh_pkg::REG_IMAGE_WIDTH: width_in = csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         odh_pkg::REG_MATRIX_MODE: csr_prdata = {28'd0, mode_ff};
         odh_pkg::REG_IMAGE_WIDTH: csr_prdata = {17'd0, width_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // Capture a new pixel whenever the input register is empty or moving on.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_gray_in  = in_gray_ff;
      in_start_in = in_start_ff;
      if (req.ready) begin
         in_valid_in = req.valid;
         in_gray_in  = req.gray_pixel;
         in_start_in = req.start_of_image;
      end
   end

   // A start flag clears the raster state ahead of its own pixel, which also
   // drops any partially built byte without emitting it.
   assign col_s = in_start_ff ? '0 : col_ff;
   assign row_s = in_start_ff ? 4'd0 : row_ff;
   assign acc_s = in_start_ff ? 8'd0 : acc_ff;
   assign col_x = XW'(col_s);

   // Effective width: zero behaves as one, anything above MAX_WIDTH is capped.
   always_comb begin
      width_ext = EW'(width_ff);
      if (width_ext == '0) begin
         eff_width = EW'(1);
      end else if (width_ext > EW'(MAX_WIDTH)) begin
         eff_width = EW'(MAX_WIDTH);
      end else begin
         eff_width = width_ext;
      end
   end

   // Comparing with at-or-past also closes the row when the width was
   // lowered while a row was in progress.
   assign eff_last = eff_width - EW'(1);
   assign last     = EW'(col_s) >= eff_last;
   assign emit     = last || (col_s[2:0] == 3'd7);

   assign thr     = odh_pkg::threshold(mode_ff, col_x[3:0], row_s);
   assign dark    = in_gray_ff < thr;
   assign acc_set = acc_s | ({7'd0, dark} << (3'd7 - col_s[2:0]));

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      if (advance) begin
         if (emit) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = acc_set;
            rsp_end_in   = last;
            acc_in       = 8'd0;
         end else begin
            acc_in = acc_set;
         end
         if (last) begin
            col_in = '0;
            row_in = row_s + 4'd1;
         end else begin
            col_in = col_s + CW'(1);
            row_in = row_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= odh_pkg::MODE_FIXED128;
         width_ff     <= odh_pkg::IMAGE_WIDTH_RESET;
         in_valid_ff  <= 1'b0;
         col_ff       <= '0;
         row_ff       <= 4'd0;
         acc_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         width_ff     <= width_in;
         in_valid_ff  <= in_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_gray_ff  <= in_gray_in;
      in_start_ff <= in_start_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   // The column never runs past the largest supported row.
   assert property (@(posedge clock) disable iff (reset)
      EW'(col_ff) <= EW'(MAX_WIDTH - 1))
      else $error("column counter beyond MAX_WIDTH");

   // Closing a row restarts the column at zero.
   assert property (@(posedge clock) disable iff (reset)
      (advance && last) |=> (col_ff == '0))
      else $error("column not cleared after row end");

   // A held pixel behind a stalled output blocks new requests.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |-> !req.ready)
      else $error("request taken while the pipeline is full");

   // Every emitted byte that is not a row end closes a group of eight pixels.
   assert property (@(posedge clock) disable iff (reset)
      (advance && emit && !last) |-> (col_s[2:0] == 3'd7))
      else $error("byte emitted inside a group of eight");

endmodule
